@@ rtl/mdlc_pkg.sv @@
`timescale 1ns / 1ps

package mdlc_pkg;

    // Field and register widths
    localparam int HOLD_W      = 22;
    localparam int PCT_W       = 7;
    localparam int MINUTE_W    = 11;
    localparam int OFFSET_W    = 10;
    localparam int LEVEL_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 22;
    localparam int TIMER_BITS_DEF = 22;

    // Milliseconds in one second for the gone event
    localparam int SECOND_MS   = 1000;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TIME     = 3'd0,
        CFG_BRIGHT_PCT    = 3'd1,
        CFG_AMBIENT_PCT   = 3'd2,
        CFG_MORNING_START = 3'd3,
        CFG_AFTER_SUNRISE = 3'd4,
        CFG_BEFORE_SUNSET = 3'd5,
        CFG_EVENING_END   = 3'd6,
        CFG_ACTIVE_LOW    = 3'd7
    } cfg_index_t;

    // Register reset values
    localparam logic [HOLD_W-1:0]   HOLD_RST          = 22'd5000;
    localparam logic [PCT_W-1:0]    BRIGHT_RST        = 7'd80;
    localparam logic [PCT_W-1:0]    AMBIENT_RST       = 7'd20;
    localparam logic [MINUTE_W-1:0] MORNING_START_RST = 11'd420;
    localparam logic [OFFSET_W-1:0] AFTER_SUNRISE_RST = 10'd10;
    localparam logic [OFFSET_W-1:0] BEFORE_SUNSET_RST = 10'd10;
    localparam logic [MINUTE_W-1:0] EVENING_END_RST   = 11'd1260;

    typedef enum logic [1:0] {
        DP_DAY     = 2'd0,
        DP_MORNING = 2'd1,
        DP_EVENING = 2'd2,
        DP_NIGHT   = 2'd3
    } day_part_t;

    // Time-of-day window settings handed to the classifier
    typedef struct packed {
        logic [MINUTE_W-1:0] morning_start;
        logic [OFFSET_W-1:0] after_sunrise;
        logic [OFFSET_W-1:0] before_sunset;
        logic [MINUTE_W-1:0] evening_end;
    } day_cfg_t;

    // floor(x / 100) as (x * 5243) >> 19, exact for x up to 127 * 255
    localparam logic [12:0] PCT_RECIP = 13'd5243;
    localparam int          PCT_SHIFT = 19;

    // Percent to PWM duty, floor(pct * 255 / 100), saturated at full scale
    function automatic logic [LEVEL_W-1:0] pct_to_level(input logic [PCT_W-1:0] pct);
        logic [14:0] scaled;
        logic [27:0] prod;
        logic [8:0]  lvl;
        scaled = {pct, 8'b0} - {8'b0, pct};
        prod   = {13'b0, scaled} * {15'b0, PCT_RECIP};
        lvl    = prod[PCT_SHIFT+8:PCT_SHIFT];
        return (lvl > 9'd255) ? 8'hFF : lvl[LEVEL_W-1:0];
    endfunction

endpackage

@@ rtl/mdlc_day_classifier.sv @@
`timescale 1ns / 1ps

module mdlc_day_classifier
    import mdlc_pkg::*;
(
    input  logic [MINUTE_W-1:0] minute_of_day,
    input  logic [MINUTE_W-1:0] sunrise_minute,
    input  logic [MINUTE_W-1:0] sunset_minute,
    input  day_cfg_t            day_cfg,
    output day_part_t           day_part
);

    logic signed [12:0] m_s;
    logic signed [12:0] rise_end_s;
    logic signed [12:0] set_start_s;
    logic signed [12:0] morning_s;
    logic signed [12:0] evening_s;

    // Morning ends after sunrise, evening starts before sunset
    always_comb
    begin
        m_s         = $signed({2'b00, minute_of_day});
        morning_s   = $signed({2'b00, day_cfg.morning_start});
        evening_s   = $signed({2'b00, day_cfg.evening_end});
        rise_end_s  = $signed({2'b00, sunrise_minute}) + $signed({3'b000, day_cfg.after_sunrise});
        set_start_s = $signed({2'b00, sunset_minute}) - $signed({3'b000, day_cfg.before_sunset});
    end

    // Strict window tests, first match wins
    always_comb
    begin
        if (m_s > morning_s && m_s < rise_end_s)
            day_part = DP_MORNING;
        else if (m_s > rise_end_s && m_s < set_start_s)
            day_part = DP_DAY;
        else if (m_s > set_start_s && m_s < evening_s)
            day_part = DP_EVENING;
        else
            day_part = DP_NIGHT;
    end

endmodule

@@ rtl/motion_daypart_light_controller.sv @@
`timescale 1ns / 1ps

// Motion and time-of-day light controller.
// Input channel (in_valid / in_stall): one word per item. kind 0 is a
// millisecond tick carrying both sensor levels; kind 1 is a time update
// carrying minute of day, sunrise and sunset.
// Output channel (out_valid / out_stall): exactly one result word per item
// with the light level, part of day, recent-motion flag and event bits.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// write only while no item is in flight.
// The word passes through the input register, then the result register that
// also updates the motion and day state; out_valid rises when that register
// loads, once the result slot is free. Throughput: one item per cycle unless
// stalled; the update path is one pass of a timer increment, a few compares
// and a small constant multiply for the level.
// When the receiver stalls, the result word holds and the input register
// fills; in_stall rises once both are occupied and the result is stalled.
// Reset: registers return to their defaults, part of day to night, timers and
// recent motion clear, and both channels come up empty.
module motion_daypart_light_controller
    import mdlc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic                  sensor_a,
    input  logic                  sensor_b,
    input  logic [MINUTE_W-1:0]   minute_of_day,
    input  logic [MINUTE_W-1:0]   sunrise_minute,
    input  logic [MINUTE_W-1:0]   sunset_minute,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LEVEL_W-1:0]    light_level,
    output logic [1:0]            day_part,
    output logic                  motion_recent,
    output logic                  event_ch_a,
    output logic                  event_ch_b,
    output logic                  event_gone,
    output logic                  event_expired
);

    localparam int CW = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX  = {TIMER_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] ONE_SEC    = TIMER_BITS'(SECOND_MS);
    localparam logic [TIMER_BITS-1:0] TWO_SEC    = TIMER_BITS'(2 * SECOND_MS);

    // Configuration registers
    logic [HOLD_W-1:0]   hold_reg;
    logic [PCT_W-1:0]    bright_reg;
    logic [PCT_W-1:0]    ambient_reg;
    day_cfg_t            day_cfg_reg;
    logic                active_low_reg;

    // Input register
    logic                s1_valid_reg;
    logic                s1_kind_reg;
    logic                s1_a_reg;
    logic                s1_b_reg;
    logic [MINUTE_W-1:0] s1_minute_reg;
    logic [MINUTE_W-1:0] s1_sunrise_reg;
    logic [MINUTE_W-1:0] s1_sunset_reg;

    // Controller state
    logic                  recent_reg,  recent_next;
    day_part_t             part_reg,    part_next;
    logic                  last_a_reg,  last_a_next;
    logic                  last_b_reg,  last_b_next;
    logic [TIMER_BITS-1:0] quiet_reg,   quiet_next;
    logic [TIMER_BITS-1:0] mark_reg,    mark_next;

    // Result register
    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  level_reg,   level_next;
    day_part_t           dp_reg;
    logic                recent_out_reg;
    logic                ev_a_reg,    ev_a_next;
    logic                ev_b_reg,    ev_b_next;
    logic                gone_reg,    gone_next;
    logic                exp_reg,     exp_next;

    logic                  out_free;
    logic                  advance;
    logic                  in_take;
    logic                  a_lvl;
    logic                  b_lvl;
    logic [TIMER_BITS-1:0] quiet_inc;
    logic [TIMER_BITS:0]   mark_limit;
    day_part_t             part_new;

    // Handshake: result slot frees when empty or taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg                  <= HOLD_RST;
            bright_reg                <= BRIGHT_RST;
            ambient_reg               <= AMBIENT_RST;
            day_cfg_reg.morning_start <= MORNING_START_RST;
            day_cfg_reg.after_sunrise <= AFTER_SUNRISE_RST;
            day_cfg_reg.before_sunset <= BEFORE_SUNSET_RST;
            day_cfg_reg.evening_end   <= EVENING_END_RST;
            active_low_reg            <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HOLD_TIME:     hold_reg                  <= cfg_data[HOLD_W-1:0];
                CFG_BRIGHT_PCT:    bright_reg                <= cfg_data[PCT_W-1:0];
                CFG_AMBIENT_PCT:   ambient_reg               <= cfg_data[PCT_W-1:0];
                CFG_MORNING_START: day_cfg_reg.morning_start <= cfg_data[MINUTE_W-1:0];
                CFG_AFTER_SUNRISE: day_cfg_reg.after_sunrise <= cfg_data[OFFSET_W-1:0];
                CFG_BEFORE_SUNSET: day_cfg_reg.before_sunset <= cfg_data[OFFSET_W-1:0];
                CFG_EVENING_END:   day_cfg_reg.evening_end   <= cfg_data[MINUTE_W-1:0];
                CFG_ACTIVE_LOW:    active_low_reg            <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_kind_reg    <= kind;
            s1_a_reg       <= sensor_a;
            s1_b_reg       <= sensor_b;
            s1_minute_reg  <= minute_of_day;
            s1_sunrise_reg <= sunrise_minute;
            s1_sunset_reg  <= sunset_minute;
        end
    end

    mdlc_day_classifier u_classifier (
        .minute_of_day  (s1_minute_reg),
        .sunrise_minute (s1_sunrise_reg),
        .sunset_minute  (s1_sunset_reg),
        .day_cfg        (day_cfg_reg),
        .day_part       (part_new)
    );

    // Next state and result for the word in the input register
    always_comb
    begin
        a_lvl       = s1_a_reg ^ active_low_reg;
        b_lvl       = s1_b_reg ^ active_low_reg;
        quiet_inc   = (quiet_reg == TIMER_MAX) ? quiet_reg : quiet_reg + 1'b1;
        mark_limit  = {1'b0, mark_reg} + (TIMER_BITS+1)'(SECOND_MS);

        recent_next = recent_reg;
        part_next   = part_reg;
        last_a_next = last_a_reg;
        last_b_next = last_b_reg;
        quiet_next  = quiet_reg;
        mark_next   = mark_reg;
        ev_a_next   = 1'b0;
        ev_b_next   = 1'b0;
        gone_next   = 1'b0;
        exp_next    = 1'b0;

        if (!s1_kind_reg)
        begin
            last_a_next = a_lvl;
            last_b_next = b_lvl;
            if (a_lvl || b_lvl)
            begin
                // activity: restart quiet timing, flag rising edges
                quiet_next  = '0;
                mark_next   = '0;
                ev_a_next   = a_lvl && !last_a_reg;
                ev_b_next   = b_lvl && !last_b_reg;
                recent_next = recent_reg || ev_a_next || ev_b_next;
            end
            else
            begin
                quiet_next = quiet_inc;
                if (recent_reg)
                begin
                    if (CW'(quiet_inc) > CW'(hold_reg))
                    begin
                        recent_next = 1'b0;
                        exp_next    = 1'b1;
                    end
                    else if ({1'b0, quiet_inc} > mark_limit)
                    begin
                        mark_next = mark_limit[TIMER_BITS-1:0];
                        gone_next = (quiet_inc >= ONE_SEC) && (quiet_inc < TWO_SEC);
                    end
                end
            end
        end
        else
        begin
            part_next = part_new;
        end

        // Light level from the updated state
        case (part_next)
            DP_DAY:              level_next = '0;
            DP_MORNING,
            DP_EVENING:          level_next = recent_next ? pct_to_level(bright_reg)
                                                          : pct_to_level(ambient_reg);
            DP_NIGHT:            level_next = recent_next ? pct_to_level(bright_reg) : '0;
            default:             level_next = '0;
        endcase
    end

    // Commit state on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= 1'b0;
            part_reg   <= DP_NIGHT;
            last_a_reg <= 1'b0;
            last_b_reg <= 1'b0;
            quiet_reg  <= '0;
            mark_reg   <= '0;
        end
        else if (advance)
        begin
            recent_reg <= recent_next;
            part_reg   <= part_next;
            last_a_reg <= last_a_next;
            last_b_reg <= last_b_next;
            quiet_reg  <= quiet_next;
            mark_reg   <= mark_next;
        end
    end

    // Result word: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            level_reg      <= level_next;
            dp_reg         <= part_next;
            recent_out_reg <= recent_next;
            ev_a_reg       <= ev_a_next;
            ev_b_reg       <= ev_b_next;
            gone_reg       <= gone_next;
            exp_reg        <= exp_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign light_level   = level_reg;
    assign day_part      = dp_reg;
    assign motion_recent = recent_out_reg;
    assign event_ch_a    = ev_a_reg;
    assign event_ch_b    = ev_b_reg;
    assign event_gone    = gone_reg;
    assign event_expired = exp_reg;

`ifndef SYNTH
    // Expiry always leaves recent motion cleared in the same word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && exp_reg |-> !recent_out_reg)
        else $error("expired word still shows recent motion");

    // A sensor edge event always comes with recent motion set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (ev_a_reg || ev_b_reg) |-> recent_out_reg)
        else $error("edge event without recent motion");

    // Daytime keeps the light off
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dp_reg == DP_DAY |-> level_reg == '0)
        else $error("light on during daytime");

    // Recent motion only drops through an expiry word
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(recent_reg) |-> out_valid_reg && exp_reg)
        else $error("recent motion cleared without expiry");

    // The second mark never runs ahead of the quiet timer
    assert property (@(posedge clk) disable iff (!rst_n)
        mark_reg <= quiet_reg)
        else $error("second mark beyond quiet time");
`endif

endmodule
